FILE: hw/rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the set-associative cache lookup
// Field widths, register indexes, the stored line layout and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int WAY_OUT_W  = 3;

  // Configuration register widths and port layout
  localparam int SET_BITS_W = 4;
  localparam int WAYS_W     = 4;
  localparam int OFFSET_W   = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd2;

  // Configuration reset values
  localparam logic [SET_BITS_W-1:0] RST_SET_INDEX_BITS = 4'd6;
  localparam logic [WAYS_W-1:0]     RST_WAYS_IN_USE    = 4'd4;
  localparam logic [OFFSET_W-1:0]   RST_OFFSET_BITS    = 5'd6;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One stored cache line (valid, tag, LRU stamp)
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } back_state_t;

endpackage

FILE: hw/rtl/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sacl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_queue: short request queue between front and back
// Small FIFO with valid/ready on both sides; push ready means not full.
// ----------------------------------------------------------------------------
module sacl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (sacl_pkg::QUEUE_DEPTH > 1) ? $clog2(sacl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sacl_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot [sacl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != CNT_W'(sacl_pkg::QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(sacl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(sacl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

FILE: hw/rtl/sacl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_front: address intake and classification
// Drops the block offset, splits the block number into set and tag, and
// pushes the request into the queue.
// ----------------------------------------------------------------------------
module sacl_front #(
  parameter int MAX_SETS = 256
) (
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [sacl_pkg::ADDR_W-1:0]                       address,
  input  logic [sacl_pkg::SET_BITS_W-1:0]                   set_index_bits,
  input  logic [sacl_pkg::OFFSET_W-1:0]                     offset_bits,
  input  logic                                              clearing,
  output logic                                              push_valid,
  input  logic                                              push_ready,
  output logic [sacl_pkg::TAG_W+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] push_data
);

  localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;

  logic [4:0]                  sb;
  logic [sacl_pkg::ADDR_W-1:0] blk;
  logic [SET_AW-1:0]           set_idx;
  logic [sacl_pkg::TAG_W-1:0]  tag;

  // Clamp set bits to what the set store holds
  always_comb begin
    if ({1'b0, set_index_bits} > 5'(SB_MAX)) begin
      sb = 5'(SB_MAX);
    end else begin
      sb = {1'b0, set_index_bits};
    end
  end

  // Block number, set index and tag
  assign blk     = address >> offset_bits;
  assign set_idx = blk[SET_AW-1:0] & ~({SET_AW{1'b1}} << sb);
  assign tag     = sacl_pkg::TAG_W'(blk >> sb);

  // No intake while the line store is being cleared
  assign push_valid = in_valid && !clearing;
  assign in_ready   = push_ready && !clearing;
  assign push_data  = {tag, set_idx};

endmodule

FILE: hw/rtl/sacl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_back: tag store lookup, LRU replacement and result register
// Reads all ways of a set, resolves hit or victim, writes the line back and
// holds the result until the receiver takes it. Clears the store after reset.
// ----------------------------------------------------------------------------
module sacl_back #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic [sacl_pkg::WAYS_W-1:0]                       ways_in_use,
  input  logic                                              q_valid,
  output logic                                              q_ready,
  input  logic [sacl_pkg::TAG_W+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_data,
  output logic                                              clearing,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic                                              hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0]                    way,
  output logic                                              replaced_valid,
  output logic [sacl_pkg::CNT_W-1:0]                        miss_total
);

  localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LEAVES = 1 << WIDX_W;
  localparam int LINE_W = $bits(sacl_pkg::line_t);

  sacl_pkg::back_state_t state;
  sacl_pkg::back_state_t state_next;

  logic [SET_AW-1:0]            clr_addr;
  logic [SET_AW-1:0]            cur_set;
  logic [sacl_pkg::TAG_W-1:0]   cur_tag;
  logic [sacl_pkg::STAMP_W-1:0] access_time;
  logic [sacl_pkg::CNT_W-1:0]   miss_count;
  logic [sacl_pkg::CNT_W-1:0]   miss_count_next;
  logic                         res_valid;
  logic                         pop;

  logic [4:0]                   nw;
  logic [LEAVES-1:0]            way_en;
  logic [MAX_WAYS-1:0]          way_we;
  logic [SET_AW-1:0]            wr_addr;
  sacl_pkg::line_t              wr_line;
  sacl_pkg::line_t              rd_line [LEAVES];

  logic [LEAVES-1:0]            hit_vec;
  logic [LEAVES-1:0]            inval_vec;
  logic                         lk_hit;
  logic                         lk_any_inval;
  logic [WIDX_W-1:0]            hit_way;
  logic [WIDX_W-1:0]            inval_way;
  logic [WIDX_W-1:0]            lru_way;
  logic [WIDX_W-1:0]            lk_way;

  logic [sacl_pkg::STAMP_W-1:0] t_stamp [WIDX_W+1][LEAVES];
  logic [WIDX_W-1:0]            t_idx   [WIDX_W+1][LEAVES];
  logic                         t_ok    [WIDX_W+1][LEAVES];

  // One RAM per way, addressed by set
  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
    sacl_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_SETS)
    ) u_line_ram (
      .clk   (clk),
      .we    (way_we[g]),
      .waddr (wr_addr),
      .wdata (wr_line),
      .raddr (q_data[SET_AW-1:0]),
      .rdata (rd_line[g])
    );
  end

  // Padding lanes of the replacement tree
  for (genvar g = MAX_WAYS; g < LEAVES; g++) begin : g_pad
    assign rd_line[g] = '0;
  end

  // Effective number of ways searched
  always_comb begin
    if (ways_in_use == '0) begin
      nw = 5'd1;
    end else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) begin
      nw = 5'(MAX_WAYS);
    end else begin
      nw = {1'b0, ways_in_use};
    end
  end

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      way_en[i] = (5'(i) < nw);
    end
  end

  // Tag compare and first invalid way
  always_comb begin
    hit_way   = '0;
    inval_way = '0;
    for (int i = 0; i < LEAVES; i++) begin
      hit_vec[i]   = way_en[i] && rd_line[i].valid && (rd_line[i].tag == cur_tag);
      inval_vec[i] = way_en[i] && !rd_line[i].valid;
    end
    for (int i = LEAVES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WIDX_W'(i);
      end
      if (inval_vec[i]) begin
        inval_way = WIDX_W'(i);
      end
    end
  end

  assign lk_hit       = |hit_vec;
  assign lk_any_inval = |inval_vec;

  // Oldest stamp: compare tree, ties go to the lower way
  always_comb begin
    for (int l = 0; l <= WIDX_W; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        t_stamp[l][i] = '0;
        t_idx[l][i]   = '0;
        t_ok[l][i]    = 1'b0;
      end
    end
    for (int i = 0; i < LEAVES; i++) begin
      t_stamp[0][i] = rd_line[i].stamp;
      t_idx[0][i]   = WIDX_W'(i);
      t_ok[0][i]    = way_en[i];
    end
    for (int l = 0; l < WIDX_W; l++) begin
      for (int i = 0; i < LEAVES / 2; i++) begin
        if (i < (LEAVES >> (l + 1))) begin
          if (t_ok[l][2*i] &&
              (!t_ok[l][2*i+1] || (t_stamp[l][2*i] <= t_stamp[l][2*i+1]))) begin
            t_stamp[l+1][i] = t_stamp[l][2*i];
            t_idx[l+1][i]   = t_idx[l][2*i];
            t_ok[l+1][i]    = t_ok[l][2*i];
          end else begin
            t_stamp[l+1][i] = t_stamp[l][2*i+1];
            t_idx[l+1][i]   = t_idx[l][2*i+1];
            t_ok[l+1][i]    = t_ok[l][2*i+1];
          end
        end
      end
    end
    lru_way = t_idx[WIDX_W][0];
  end

  // Way to write: hit way, else first invalid, else LRU
  always_comb begin
    if (lk_hit) begin
      lk_way = hit_way;
    end else if (lk_any_inval) begin
      lk_way = inval_way;
    end else begin
      lk_way = lru_way;
    end
  end

  assign miss_count_next = lk_hit ? miss_count : miss_count + 1'b1;

  // Take a request when the result slot is free or being drained
  assign pop = (state == sacl_pkg::S_IDLE) && q_valid && (!res_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sacl_pkg::S_CLEAR: begin
        if (clr_addr == SET_AW'(MAX_SETS - 1)) begin
          state_next = sacl_pkg::S_IDLE;
        end
      end
      sacl_pkg::S_IDLE: begin
        if (pop) begin
          state_next = sacl_pkg::S_LOOKUP;
        end
      end
      sacl_pkg::S_LOOKUP: begin
        state_next = sacl_pkg::S_IDLE;
      end
      default: begin
        state_next = sacl_pkg::S_CLEAR;
      end
    endcase
  end

  // Outputs of the sequencer: store writes and queue handshake
  always_comb begin
    way_we   = '0;
    wr_addr  = cur_set;
    wr_line  = '0;
    clearing = 1'b0;
    q_ready  = 1'b0;
    case (state)
      sacl_pkg::S_CLEAR: begin
        clearing = 1'b1;
        way_we   = '1;
        wr_addr  = clr_addr;
      end
      sacl_pkg::S_IDLE: begin
        q_ready = pop;
      end
      sacl_pkg::S_LOOKUP: begin
        wr_line.valid = 1'b1;
        wr_line.tag   = cur_tag;
        wr_line.stamp = access_time;
        for (int i = 0; i < MAX_WAYS; i++) begin
          way_we[i] = (lk_way == WIDX_W'(i));
        end
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sacl_pkg::S_CLEAR;
      clr_addr    <= '0;
      access_time <= '0;
      miss_count  <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sacl_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == sacl_pkg::S_LOOKUP) begin
        access_time <= access_time + 1'b1;
        miss_count  <= miss_count_next;
        res_valid   <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_set <= q_data[SET_AW-1:0];
      cur_tag <= q_data[SET_AW +: sacl_pkg::TAG_W];
    end
    if (state == sacl_pkg::S_LOOKUP) begin
      hit            <= lk_hit;
      way            <= sacl_pkg::WAY_OUT_W'(lk_way);
      replaced_valid <= !lk_hit && !lk_any_inval;
      miss_total     <= miss_count_next;
    end
  end

  assign out_valid = res_valid;

`ifndef SYNTHESIS
  // Every lookup produces a result beat
  a_lookup_result: assert property (@(posedge clk) disable iff (rst)
    (state == sacl_pkg::S_LOOKUP) |=> res_valid)
    else $error("lookup finished without a result");

  // A lookup writes exactly one way
  a_one_way_write: assert property (@(posedge clk) disable iff (rst)
    (state == sacl_pkg::S_LOOKUP) |-> $onehot(way_we))
    else $error("lookup wrote other than one way");

  // The store is written only while clearing or on a lookup
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    (|way_we) |-> (state == sacl_pkg::S_CLEAR || state == sacl_pkg::S_LOOKUP))
    else $error("line store written outside clear or lookup");

  // A hit leaves the miss count alone
  a_hit_no_miss: assert property (@(posedge clk) disable iff (rst)
    (state == sacl_pkg::S_LOOKUP && lk_hit) |=> $stable(miss_count))
    else $error("miss count moved on a hit");

  // No request is taken while clearing or while a result waits unclaimed
  a_pop_guard: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> (!clearing && (!res_valid || out_ready)))
    else $error("request taken while busy");
`endif

endmodule

FILE: hw/rtl/set_assoc_cache_lru_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup: set-associative cache lookup with LRU fill
// Classifies each address into set and tag, looks it up across the ways of
// that set, refreshes or fills a line and reports hit, way and miss count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, address): one beat per access.
//   Output channel (out_valid/out_ready, hit, way, replaced_valid,
//   miss_total): one result beat per access, in order.
//   Config port (cfg_we, cfg_index, cfg_data): 0 set_index_bits,
//   1 ways_in_use, 2 offset_bits; other indexes are ignored. Write only
//   while no access is in flight.
//   Path: request queue, registered line RAM read, result register.
//   Pacing: the lookup unit reads, then writes the addressed set in the
//   per-way line RAMs (one port each) before it takes the next access.
//   Reset: clears counters and config to defaults, then walks all MAX_SETS
//   sets invalidating lines, one set per cycle; in_ready stays low
//   until the walk is done.
//   Stall: a result held by a low out_ready stops the lookup unit; a
//   two-entry queue keeps taking addresses until it is full.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sacl_pkg::ADDR_W-1:0]     address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0]  way,
  output logic                            replaced_valid,
  output logic [sacl_pkg::CNT_W-1:0]      miss_total,
  input  logic                            cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int REQ_W  = sacl_pkg::TAG_W + SET_AW;

  logic [sacl_pkg::SET_BITS_W-1:0] set_index_bits;
  logic [sacl_pkg::WAYS_W-1:0]     ways_in_use;
  logic [sacl_pkg::OFFSET_W-1:0]   offset_bits;

  logic             clearing;
  logic             push_valid;
  logic             push_ready;
  logic [REQ_W-1:0] push_data;
  logic             q_valid;
  logic             q_ready;
  logic [REQ_W-1:0] q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= sacl_pkg::RST_SET_INDEX_BITS;
      ways_in_use    <= sacl_pkg::RST_WAYS_IN_USE;
      offset_bits    <= sacl_pkg::RST_OFFSET_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        sacl_pkg::REG_SET_INDEX_BITS: set_index_bits <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::REG_WAYS_IN_USE:    ways_in_use    <= cfg_data[sacl_pkg::WAYS_W-1:0];
        sacl_pkg::REG_OFFSET_BITS:    offset_bits    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: intake and classification
  sacl_front #(
    .MAX_SETS (MAX_SETS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .address        (address),
    .set_index_bits (set_index_bits),
    .offset_bits    (offset_bits),
    .clearing       (clearing),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  // Request queue
  sacl_queue #(
    .WIDTH (REQ_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // Back: lookup, replacement and result
  sacl_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .ways_in_use    (ways_in_use),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way            (way),
    .replaced_valid (replaced_valid),
    .miss_total     (miss_total)
  );

endmodule

FILE: verif/set_assoc_cache_lru_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_tb: self-checking bench for the LRU cache lookup
// Streams byte addresses into the lookup block under several register
// settings, mirrors the tag, valid and stamp arrays to work out hit, way,
// eviction and miss count per access, and compares each result beat in order.
// Both channels idle and stall in random bursts; the last phase runs at full
// rate.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_tb;

  localparam int NUM_SETS   = 256;
  localparam int NUM_WAYS   = 8;
  localparam int POOL_SIZE  = 10;
  localparam int QUIET_MAX  = 4000;
  localparam int RAND_BATCH = 125;
  localparam int NUM_BATCH  = 8;

  // Index past the last register; writes to it must be dropped
  localparam logic [sacl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                           hit;
    logic [sacl_pkg::WAY_OUT_W-1:0] way;
    logic                           replaced_valid;
    logic [sacl_pkg::CNT_W-1:0]     miss_total;
  } lookup_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [sacl_pkg::ADDR_W-1:0]     address = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            hit;
  logic [sacl_pkg::WAY_OUT_W-1:0]  way;
  logic                            replaced_valid;
  logic [sacl_pkg::CNT_W-1:0]      miss_total;
  logic                            cfg_we = 1'b0;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_lru_lookup #(
    .MAX_SETS(NUM_SETS),
    .MAX_WAYS(NUM_WAYS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .address       (address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .way           (way),
    .replaced_valid(replaced_valid),
    .miss_total    (miss_total),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Mirror of the cache state and register settings
  bit                           cache_valid [NUM_WAYS][NUM_SETS];
  logic [sacl_pkg::TAG_W-1:0]   cache_tag   [NUM_WAYS][NUM_SETS];
  logic [sacl_pkg::STAMP_W-1:0] cache_stamp [NUM_WAYS][NUM_SETS];
  logic [sacl_pkg::STAMP_W-1:0] access_clock = '0;
  logic [sacl_pkg::CNT_W-1:0]   miss_tally = '0;
  logic [sacl_pkg::SET_BITS_W-1:0] set_bits_reg = sacl_pkg::RST_SET_INDEX_BITS;
  logic [sacl_pkg::WAYS_W-1:0]     ways_reg     = sacl_pkg::RST_WAYS_IN_USE;
  logic [sacl_pkg::OFFSET_W-1:0]   offset_reg   = sacl_pkg::RST_OFFSET_BITS;

  lookup_result_t              expected_lookups[$];
  logic [sacl_pkg::ADDR_W-1:0] pending_addresses[$];
  logic [sacl_pkg::TAG_W-1:0]  tag_pool[POOL_SIZE];

  int errors = 0;
  int items_queued = 0;
  int results_seen = 0;
  int gap_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int quiet = 0;

  initial begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        cache_valid[w][s] = 1'b0;
        cache_tag[w][s]   = '0;
        cache_stamp[w][s] = '0;
      end
    end
  end

  // Set bits beyond the set count fall back to the largest that fits
  function automatic int unsigned eff_set_bits();
    return (set_bits_reg > $clog2(NUM_SETS)) ? $clog2(NUM_SETS) : set_bits_reg;
  endfunction

  // Zero ways acts as one, too many acts as the full width
  function automatic int unsigned eff_ways();
    if (ways_reg == 0) return 1;
    if (ways_reg > NUM_WAYS) return NUM_WAYS;
    return ways_reg;
  endfunction

  // Look up one address, update the mirrored lines and return the result
  function automatic lookup_result_t predict_lookup(input logic [sacl_pkg::ADDR_W-1:0] addr);
    lookup_result_t r;
    logic [31:0] blk;
    logic [31:0] tag;
    int unsigned sb;
    int unsigned nw;
    int unsigned set_idx;
    int unsigned pick;
    bit found;
    bit open;
    blk = addr >> offset_reg;
    sb = eff_set_bits();
    nw = eff_ways();
    set_idx = blk & ((32'd1 << sb) - 32'd1);
    tag = blk >> sb;
    found = 1'b0;
    open = 1'b0;
    pick = 0;
    for (int w = 0; w < nw; w++) begin
      if (!found && cache_valid[w][set_idx] && cache_tag[w][set_idx] == tag) begin
        found = 1'b1;
        pick = w;
      end
    end
    r.replaced_valid = 1'b0;
    if (found) begin
      cache_stamp[pick][set_idx] = access_clock;
    end else begin
      miss_tally++;
      // first free way wins, else lowest way with the smallest stamp
      for (int w = 0; w < nw; w++) begin
        if (!open) begin
          if (!cache_valid[w][set_idx]) begin
            pick = w;
            open = 1'b1;
          end else if (cache_stamp[w][set_idx] < cache_stamp[pick][set_idx]) begin
            pick = w;
          end
        end
      end
      r.replaced_valid = cache_valid[pick][set_idx];
      cache_valid[pick][set_idx] = 1'b1;
      cache_tag[pick][set_idx]   = tag;
      cache_stamp[pick][set_idx] = access_clock;
    end
    access_clock++;
    r.hit = found;
    r.way = pick[sacl_pkg::WAY_OUT_W-1:0];
    r.miss_total = miss_tally;
    return r;
  endfunction

  // Address generator: mostly a small working set per set, some wild ones
  function automatic logic [sacl_pkg::ADDR_W-1:0] make_address();
    logic [31:0] blk;
    logic [31:0] low_mask;
    int unsigned sb;
    int unsigned pick;
    sb = eff_set_bits();
    if ($urandom_range(0, 4) == 0) return $urandom;
    pick = $urandom_range(0, eff_ways() + 1);
    blk = (tag_pool[pick] << sb) | ($urandom_range(0, 3) & ((32'd1 << sb) - 32'd1));
    low_mask = (32'd1 << offset_reg) - 32'd1;
    return (blk << offset_reg) | ($urandom & low_mask);
  endfunction

  task automatic queue_address(input logic [sacl_pkg::ADDR_W-1:0] addr);
    pending_addresses.push_back(addr);
    items_queued++;
  endtask

  task automatic write_reg(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sacl_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sacl_pkg::REG_SET_INDEX_BITS: set_bits_reg = val[sacl_pkg::SET_BITS_W-1:0];
      sacl_pkg::REG_WAYS_IN_USE:    ways_reg     = val[sacl_pkg::WAYS_W-1:0];
      sacl_pkg::REG_OFFSET_BITS:    offset_reg   = val[sacl_pkg::OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: presents queued addresses, predicts on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_lookups.push_back(predict_lookup(address));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_addresses.size() > 0) begin
          in_valid <= 1'b1;
          address  <= pending_addresses.pop_front();
          if ($urandom_range(0, 99) < gap_pct) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_lookups.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got hit=%0b way=%0d",
                   $time, hit, way);
          errors++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", want.hit, hit);
          check_field("way", want.way, way);
          check_field("replaced_valid", want.replaced_valid, replaced_valid);
          check_field("miss_total", want.miss_total, miss_total);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < gap_pct) out_gap = $urandom_range(1, 5);
      end
    end
  end

  // Watchdog: covers the post-reset clearing pass with room to spare
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_MAX);
        $display("set_assoc_cache_lru_lookup_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 64 sets, 4 ways, 64-byte lines
    gap_pct = 20;
    queue_address(32'h0000_0000);  // cold miss, way 0
    queue_address(32'h0000_003f);  // same line, hit
    queue_address(32'hffff_ffff);  // all ones, top set
    queue_address(32'hffff_ffc0);  // hit on the all-ones line
    queue_address(32'h0000_1000);  // fill the rest of set 0
    queue_address(32'h0000_2000);
    queue_address(32'h0000_3000);
    queue_address(32'h0000_0000);  // refresh way 0
    queue_address(32'h0000_4000);  // full set, evict the oldest
    queue_address(32'h0000_1000);  // evicted earlier, misses again
    queue_address(32'h0000_3000);
    queue_address(32'h8000_0000);
    queue_address(32'h0000_0040);
    wait_drained();

    // Too many set bits, zero ways, no offset; unused index is dropped
    write_reg(sacl_pkg::REG_SET_INDEX_BITS, 5'd15);
    write_reg(sacl_pkg::REG_WAYS_IN_USE, 5'd0);
    write_reg(sacl_pkg::REG_OFFSET_BITS, 5'd0);
    write_reg(REG_UNUSED, 5'd31);
    end_writes();
    queue_address(32'h0000_0000);
    queue_address(32'h0000_0100);  // same set, single way, evicts
    queue_address(32'h0000_0000);
    queue_address(32'h0000_00ff);
    queue_address(32'hffff_ffff);
    wait_drained();

    // Too many ways, widest offset, one set bit past the limit
    write_reg(sacl_pkg::REG_SET_INDEX_BITS, 5'd9);
    write_reg(sacl_pkg::REG_WAYS_IN_USE, 5'd15);
    write_reg(sacl_pkg::REG_OFFSET_BITS, 5'd31);
    end_writes();
    queue_address(32'h0000_0000);
    queue_address(32'h8000_0000);
    queue_address(32'h7fff_ffff);
    queue_address(32'h8000_0001);
    wait_drained();

    // Random batches under changing settings; the last runs without gaps
    for (int b = 0; b < NUM_BATCH; b++) begin
      write_reg(sacl_pkg::REG_SET_INDEX_BITS,
                (b % 4 == 0) ? 5'd0 : 5'($urandom_range(0, 15)));
      write_reg(sacl_pkg::REG_WAYS_IN_USE,
                (b % 3 == 0) ? 5'd8 : 5'($urandom_range(0, 15)));
      write_reg(sacl_pkg::REG_OFFSET_BITS,
                (b % 2 == 0) ? 5'($urandom_range(0, 12)) : 5'($urandom_range(0, 31)));
      end_writes();
      for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
      gap_pct = (b == NUM_BATCH - 1) ? 0 : ((b % 3 == 1) ? 0 : $urandom_range(10, 40));
      for (int i = 0; i < RAND_BATCH; i++) queue_address(make_address());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_lookups.size());
      errors++;
    end
    if (errors == 0) begin
      $display("set_assoc_cache_lru_lookup_tb: PASS");
    end else begin
      $display("set_assoc_cache_lru_lookup_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_queue.sv
hw/rtl/sacl_front.sv
hw/rtl/sacl_back.sv
hw/rtl/set_assoc_cache_lru_lookup.sv
verif/set_assoc_cache_lru_lookup_tb.sv
